// ----- rtl/cpu_segment_decode_scratchpad_defines.svh -----
// Assertion macros shared by the segment decode and scratchpad RTL.
// Every macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef CPU_SEGMENT_DECODE_SCRATCHPAD_DEFINES_SVH
`define CPU_SEGMENT_DECODE_SCRATCHPAD_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CSDS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csds same-cycle check failed");

// Next-cycle implication, checked outside reset
`define CSDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csds next-cycle check failed");

`endif

// ----- rtl/csds_pkg.sv -----
// Shared types, codes and constants for the segment decode and scratchpad block.
// No dependencies; used by csds_decode and the top level.
package csds_pkg;

  localparam int          PHYS_W            = 29;
  localparam int          SCRATCH_BYTES_DEF = 1024;
  localparam logic [31:0] CACHE_CTRL_ADDR   = 32'hFFFE0130;
  localparam logic [28:0] BASE_RESET        = 29'h1F800000;

  // Configuration register index (byte address bit 2)
  localparam logic REG_SCRATCH_BASE = 1'b0;

  // Access kind and size codes
  localparam logic       KIND_STORE = 1'b1;
  localparam logic [1:0] SZ_BYTE    = 2'd0;
  localparam logic [1:0] SZ_HALF    = 2'd1;

  // Segment codes (virtual address bits 31:29)
  localparam logic [2:0] SEG_USER     = 3'd0;
  localparam logic [2:0] SEG_CACHED   = 3'd4;
  localparam logic [2:0] SEG_UNCACHED = 3'd5;

  // Route codes
  localparam logic [2:0] ROUTE_SCRATCH  = 3'd0;
  localparam logic [2:0] ROUTE_BUS      = 3'd1;
  localparam logic [2:0] ROUTE_CCTRL    = 3'd2;
  localparam logic [2:0] ROUTE_DROP     = 3'd3;
  localparam logic [2:0] ROUTE_BUSERR   = 3'd4;
  localparam logic [2:0] ROUTE_LOAD_AE  = 3'd5;
  localparam logic [2:0] ROUTE_STORE_AE = 3'd6;

  typedef struct packed {
    logic        kind;
    logic [1:0]  access_size;
    logic [31:0] virt_address;
    logic [31:0] write_data;
    logic        isolate_cache;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        route;
    logic [PHYS_W-1:0] phys_address;
    logic [31:0]       read_data;
    logic [31:0]       bus_data;
    logic [31:0]       fault_address;
  } out_item_t;

  // Write-back controls from the decode to the state holders
  typedef struct packed {
    logic        mem_we;
    logic [31:0] mem_wdata;
    logic        cctrl_we;
    logic [31:0] cctrl_wdata;
  } wr_ctl_t;

endpackage

// ----- rtl/csds_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module csds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; hold data when no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/csds_decode.sv -----
// Alignment check, segment decode and scratchpad lane merge for one access.
// Depends on csds_pkg.
module csds_decode #(
  parameter int SCRATCH_BYTES = csds_pkg::SCRATCH_BYTES_DEF
) (
  input  csds_pkg::in_item_t           item,
  input  logic [csds_pkg::PHYS_W-1:0]  base,
  input  logic [31:0]                  ram_word,
  input  logic [31:0]                  cctrl,
  output csds_pkg::out_item_t          res,
  output csds_pkg::wr_ctl_t            wr
);

  localparam int OB = $clog2(SCRATCH_BYTES);

  logic [31:0]                 va;
  logic [31:0]                 msk;
  logic [31:0]                 data;
  logic [31:0]                 rd_lane;
  logic [31:0]                 merged;
  logic [2:0]                  seg;
  logic [csds_pkg::PHYS_W-1:0] phys;
  logic                        store;
  logic                        misalign;
  logic                        in_win;

  assign va    = item.virt_address;
  assign seg   = va[31:29];
  assign phys  = va[csds_pkg::PHYS_W-1:0];
  assign store = (item.kind == csds_pkg::KIND_STORE);
  assign data  = item.write_data & msk;

  // Select the window by the address bits above the scratchpad size
  assign in_win = (phys[csds_pkg::PHYS_W-1:OB] == base[csds_pkg::PHYS_W-1:OB]);

  // Size mask and alignment
  always_comb begin
    case (item.access_size)
      csds_pkg::SZ_BYTE: begin
        msk      = 32'h0000_00FF;
        misalign = 1'b0;
      end
      csds_pkg::SZ_HALF: begin
        msk      = 32'h0000_FFFF;
        misalign = va[0];
      end
      default: begin
        msk      = 32'hFFFF_FFFF;
        misalign = |va[1:0];
      end
    endcase
  end

  // Extract the load lanes and merge the store lanes of the addressed word
  always_comb begin
    rd_lane = ram_word;
    merged  = ram_word;
    case (item.access_size)
      csds_pkg::SZ_BYTE: begin
        case (va[1:0])
          2'd0: begin
            rd_lane      = {24'd0, ram_word[7:0]};
            merged[7:0]  = data[7:0];
          end
          2'd1: begin
            rd_lane      = {24'd0, ram_word[15:8]};
            merged[15:8] = data[7:0];
          end
          2'd2: begin
            rd_lane       = {24'd0, ram_word[23:16]};
            merged[23:16] = data[7:0];
          end
          default: begin
            rd_lane       = {24'd0, ram_word[31:24]};
            merged[31:24] = data[7:0];
          end
        endcase
      end
      csds_pkg::SZ_HALF: begin
        if (va[1]) begin
          rd_lane       = {16'd0, ram_word[31:16]};
          merged[31:16] = data[15:0];
        end else begin
          rd_lane       = {16'd0, ram_word[15:0]};
          merged[15:0]  = data[15:0];
        end
      end
      default: begin
        rd_lane = ram_word;
        merged  = data;
      end
    endcase
  end

  // Route the access
  always_comb begin
    res.route         = csds_pkg::ROUTE_BUSERR;
    res.phys_address  = phys;
    res.read_data     = '0;
    res.bus_data      = '0;
    res.fault_address = '0;
    wr.mem_we         = 1'b0;
    wr.mem_wdata      = merged;
    wr.cctrl_we       = 1'b0;
    wr.cctrl_wdata    = data;
    if (misalign) begin
      res.route         = store ? csds_pkg::ROUTE_STORE_AE : csds_pkg::ROUTE_LOAD_AE;
      res.fault_address = va;
    end else if (seg inside {csds_pkg::SEG_USER, csds_pkg::SEG_CACHED}) begin
      if (store && item.isolate_cache) begin
        res.route = csds_pkg::ROUTE_DROP;
      end else if (in_win) begin
        res.route = csds_pkg::ROUTE_SCRATCH;
        if (store) begin
          wr.mem_we = 1'b1;
        end else begin
          res.read_data = rd_lane;
        end
      end else begin
        res.route = csds_pkg::ROUTE_BUS;
        if (store) begin
          res.bus_data = data;
        end
      end
    end else if (seg == csds_pkg::SEG_UNCACHED) begin
      res.route = csds_pkg::ROUTE_BUS;
      if (store) begin
        res.bus_data = data;
      end
    end else if (va == csds_pkg::CACHE_CTRL_ADDR) begin
      res.route = csds_pkg::ROUTE_CCTRL;
      if (store) begin
        wr.cctrl_we = 1'b1;
      end else begin
        res.read_data = cctrl & msk;
      end
    end
  end

endmodule

// ----- rtl/cpu_segment_decode_scratchpad.sv -----
// Accepted transactions pass s1_item_r then out_data_r, one per cycle unless out_stall
// holds; the scratchpad word read at acceptance is modified and written back as s1
// advances, with a forward path for a back-to-back hit. Reset: clears cache control,
// loads the scratchpad base, then sweeps all SCRATCH_BYTES/4 words (256 at the default)
// to zero one word a cycle with in_stall held.
`include "cpu_segment_decode_scratchpad_defines.svh"
module cpu_segment_decode_scratchpad #(
  parameter int SCRATCH_BYTES = csds_pkg::SCRATCH_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  csds_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output csds_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int WORDS = SCRATCH_BYTES / 4;
  localparam int AW    = $clog2(WORDS);

  // Pipeline and state registers
  logic                        s1_valid_r;
  csds_pkg::in_item_t          s1_item_r;
  logic                        fwd_r;
  logic [31:0]                 fwd_word_r;
  logic                        out_valid_r;
  csds_pkg::out_item_t         out_data_r;
  logic [31:0]                 cctrl_r;
  logic [csds_pkg::PHYS_W-1:0] base_r;
  logic                        clear_busy_r;
  logic [AW-1:0]               clear_cnt_r;

  logic                        accept;
  logic                        s1_adv;
  logic [AW-1:0]               s1_idx;
  logic [AW-1:0]               in_idx;
  logic [31:0]                 ram_rdata;
  logic [31:0]                 s1_word;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [31:0]                 mem_wdata;
  logic                        cfg_we;
  csds_pkg::out_item_t         res;
  csds_pkg::wr_ctl_t           wr;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clear_busy_r || (s1_valid_r && !s1_adv);
  assign accept   = in_valid && !in_stall;
  assign in_idx   = in_data.virt_address[AW+1:2];
  assign s1_idx   = s1_item_r.virt_address[AW+1:2];
  assign s1_word  = fwd_r ? fwd_word_r : ram_rdata;

  // Share the write port between the clearing sweep and store write-back
  assign mem_we    = clear_busy_r || (s1_adv && wr.mem_we);
  assign mem_waddr = clear_busy_r ? clear_cnt_r : s1_idx;
  assign mem_wdata = clear_busy_r ? '0 : wr.mem_wdata;

  csds_ram #(
    .WIDTH (32),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  csds_decode #(
    .SCRATCH_BYTES (SCRATCH_BYTES)
  ) u_decode (
    .item     (s1_item_r),
    .base     (base_r),
    .ram_word (s1_word),
    .cctrl    (cctrl_r),
    .res      (res),
    .wr       (wr)
  );

  // Sweep the scratchpad to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_busy_r <= 1'b1;
      clear_cnt_r  <= '0;
    end else if (clear_busy_r) begin
      clear_cnt_r <= clear_cnt_r + 1'b1;
      if (clear_cnt_r == AW'(WORDS - 1)) begin
        clear_busy_r <= 1'b0;
      end
    end
  end

  // Advance the access stage and track forwarding of a same-word write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
      fwd_r      <= s1_adv && wr.mem_we && (s1_idx == in_idx);
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r  <= in_data;
      fwd_word_r <= wr.mem_wdata;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  // Update cache control on a committed store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cctrl_r <= '0;
    end else if (s1_adv && wr.cctrl_we) begin
      cctrl_r <= wr.cctrl_wdata;
    end
  end

  // Configuration register write
  assign cfg_we = psel && penable && pwrite && pready
                  && (paddr[2] == csds_pkg::REG_SCRATCH_BASE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= csds_pkg::BASE_RESET;
    end else if (cfg_we) begin
      base_r <= pwdata[csds_pkg::PHYS_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == csds_pkg::REG_SCRATCH_BASE)
                  ? {{(32 - csds_pkg::PHYS_W){1'b0}}, base_r} : '0;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `CSDS_ASSERT_NOW(a_clear_pipe_empty, clear_busy_r, !s1_valid_r && !out_valid_r)
  `CSDS_ASSERT_NOW(a_fwd_needs_item, fwd_r, s1_valid_r)
  `CSDS_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_item_r))
  `CSDS_ASSERT_NOW(a_ram_write_owner, mem_we && !clear_busy_r, s1_adv && wr.mem_we)

endmodule

// ----- verif/tb_cpu_segment_decode_scratchpad.sv -----
// Testbench for cpu_segment_decode_scratchpad: directed and random loads and stores,
// checked against an in-bench model of segment decode, scratchpad RAM and cache control.
// Depends on csds_pkg and the top-level RTL only.
module tb_cpu_segment_decode_scratchpad;

  localparam int          SCRATCH_BYTES = csds_pkg::SCRATCH_BYTES_DEF;
  localparam int          IW            = $clog2(SCRATCH_BYTES);
  localparam logic        KIND_LOAD     = 1'b0;
  localparam logic [1:0]  SZ_WORD       = 2'd2;
  localparam logic [1:0]  SZ_ODD        = 2'd3;
  localparam logic [2:0]  SEG_KERNEL    = 3'd6;
  localparam int          RANDOM_PHASE  = 500;
  localparam int          HOLD_AT       = 700;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          CYCLE_LIMIT   = 400000;

  typedef struct {
    csds_pkg::in_item_t acc;
    int unsigned        gap;
  } pending_access_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid = 1'b0;
  logic                in_stall;
  csds_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  csds_pkg::out_item_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Model state
  logic [7:0]  scratch_copy [SCRATCH_BYTES];
  logic [31:0] cctrl_copy;
  logic [28:0] base_copy;

  pending_access_t     pending_accesses[$];
  csds_pkg::out_item_t expected_results[$];
  int                  mismatches = 0;
  bit                  rx_calm = 1'b0;
  int unsigned         cycle_count = 0;

  cpu_segment_decode_scratchpad #(.SCRATCH_BYTES(SCRATCH_BYTES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Compute the result of one access and apply its side effects to the model state
  function automatic csds_pkg::out_item_t decode_access(csds_pkg::in_item_t a);
    csds_pkg::out_item_t r;
    logic [31:0]         size_mask;
    int unsigned         nbytes;
    logic [31:0]         data;
    logic [31:0]         align_mask;
    logic [2:0]          seg;
    logic [28:0]         win_mask;
    logic [28:0]         phys;
    logic [IW-1:0]       idx;
    r = '0;
    phys = a.virt_address[28:0];
    r.phys_address = phys;
    case (a.access_size)
      csds_pkg::SZ_BYTE: begin
        size_mask = 32'h0000_00FF;
        nbytes = 1;
      end
      csds_pkg::SZ_HALF: begin
        size_mask = 32'h0000_FFFF;
        nbytes = 2;
      end
      default: begin
        size_mask = 32'hFFFF_FFFF;
        nbytes = 4;
      end
    endcase
    data = a.write_data & size_mask;
    align_mask = nbytes - 1;
    seg = a.virt_address[31:29];
    win_mask = ~29'(SCRATCH_BYTES - 1);
    if ((a.virt_address & align_mask) != 0) begin
      r.route = (a.kind == csds_pkg::KIND_STORE) ? csds_pkg::ROUTE_STORE_AE
                                                 : csds_pkg::ROUTE_LOAD_AE;
      r.fault_address = a.virt_address;
    end else if (seg == csds_pkg::SEG_USER || seg == csds_pkg::SEG_CACHED) begin
      if (a.kind == csds_pkg::KIND_STORE && a.isolate_cache) begin
        r.route = csds_pkg::ROUTE_DROP;
      end else if ((phys & win_mask) == (base_copy & win_mask)) begin
        r.route = csds_pkg::ROUTE_SCRATCH;
        for (int i = 0; i < nbytes; i++) begin
          idx = phys[IW-1:0] + IW'(i);
          if (a.kind == csds_pkg::KIND_STORE) scratch_copy[idx] = data[8*i +: 8];
          else r.read_data[8*i +: 8] = scratch_copy[idx];
        end
      end else begin
        r.route = csds_pkg::ROUTE_BUS;
        if (a.kind == csds_pkg::KIND_STORE) r.bus_data = data;
      end
    end else if (seg == csds_pkg::SEG_UNCACHED) begin
      r.route = csds_pkg::ROUTE_BUS;
      if (a.kind == csds_pkg::KIND_STORE) r.bus_data = data;
    end else if (a.virt_address == csds_pkg::CACHE_CTRL_ADDR) begin
      r.route = csds_pkg::ROUTE_CCTRL;
      if (a.kind == csds_pkg::KIND_STORE) cctrl_copy = data;
      else r.read_data = cctrl_copy & size_mask;
    end else begin
      r.route = csds_pkg::ROUTE_BUSERR;
    end
    return r;
  endfunction

  task automatic queue_access(input logic kind, input logic [1:0] sz,
                              input logic [31:0] va, input logic [31:0] wd,
                              input logic iso, input int unsigned gap);
    pending_access_t p;
    p.acc.kind          = kind;
    p.acc.access_size   = sz;
    p.acc.virt_address  = va;
    p.acc.write_data    = wd;
    p.acc.isolate_cache = iso;
    p.gap               = gap;
    pending_accesses.push_back(p);
  endtask

  // Pick an address spread over the segments, biased toward the scratchpad window
  function automatic logic [31:0] pick_address(logic [1:0] sz);
    logic [31:0] va;
    logic [28:0] win_mask;
    logic [28:0] offset;
    int unsigned r;
    win_mask = ~29'(SCRATCH_BYTES - 1);
    r = $urandom_range(0, 99);
    offset = ($urandom_range(0, 3) == 0) ? 29'($urandom_range(0, SCRATCH_BYTES - 1))
                                          : 29'($urandom_range(0, 63));
    if (r < 45)
      va = {($urandom_range(0, 1) ? csds_pkg::SEG_CACHED : csds_pkg::SEG_USER),
            (base_copy & win_mask) | offset};
    else if (r < 55)
      va = csds_pkg::CACHE_CTRL_ADDR;
    else if (r < 65)
      va = {csds_pkg::SEG_UNCACHED, 29'($urandom)};
    else if (r < 75)
      va = {SEG_KERNEL[2:1], 1'($urandom_range(0, 1)), 29'($urandom)};
    else if (r < 82)
      va = {3'($urandom_range(1, 3)), 29'($urandom)};
    else if (r < 90)
      va = {($urandom_range(0, 1) ? csds_pkg::SEG_CACHED : csds_pkg::SEG_USER),
            29'($urandom)};
    else
      va = $urandom;
    // Keep most accesses aligned
    if ($urandom_range(0, 9) != 0) begin
      if (sz == csds_pkg::SZ_HALF) va[0] = 1'b0;
      else if (sz != csds_pkg::SZ_BYTE) va[1:0] = 2'b00;
    end
    return va;
  endfunction

  task automatic fill_random(input int count, input bit calm);
    logic [1:0]  sz;
    int unsigned r;
    int unsigned gap;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      sz = (r < 3) ? csds_pkg::SZ_BYTE : (r < 6) ? csds_pkg::SZ_HALF
         : (r < 9) ? SZ_WORD : SZ_ODD;
      if (calm || $urandom_range(0, 9) < 3) gap = 0;
      else gap = $urandom_range(0, 14);
      queue_access(1'($urandom_range(0, 1)), sz, pick_address(sz), $urandom,
                   ($urandom_range(0, 5) == 0), gap);
    end
  endtask

  task automatic write_scratch_base(input logic [28:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {csds_pkg::REG_SCRATCH_BASE, 2'b00};
    pwdata  <= {3'b000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    base_copy = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold until every queued access is accepted and every result has come back
  task automatic wait_drained();
    while (pending_accesses.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // Driver: offer pending accesses, predict each one at acceptance
  int unsigned idle_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(decode_access(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_accesses.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else begin
          in_data  <= pending_accesses[0].acc;
          in_valid <= 1'b1;
          idle_left = (pending_accesses.size() > 1) ? pending_accesses[1].gap : 0;
          void'(pending_accesses.pop_front());
        end
      end
    end
  end

  // Monitor: check each transaction, stall at random, hold off once for a long stretch
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned results_seen = 0;
  always @(posedge clk) begin : rx_proc
    csds_pkg::out_item_t want;
    bit                  took;
    int unsigned         w;
    took = 1'b0;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        took = 1'b1;
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none actual %h", $time, out_data);
        end else begin
          want = expected_results.pop_front();
          compare_field("route", 32'(want.route), 32'(out_data.route));
          compare_field("phys_address", 32'(want.phys_address),
                        32'(out_data.phys_address));
          compare_field("read_data", want.read_data, out_data.read_data);
          compare_field("bus_data", want.bus_data, out_data.bus_data);
          compare_field("fault_address", want.fault_address, out_data.fault_address);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall <= 1'b1;
      end else if (took) begin
        w = (rx_calm || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 14);
        out_stall <= (w > 0);
        rx_wait = (w > 0) ? w - 1 : 0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    logic [28:0] phase_base [4];
    foreach (scratch_copy[i]) scratch_copy[i] = 8'h00;
    cctrl_copy = '0;
    base_copy  = csds_pkg::BASE_RESET;
    phase_base[0] = 29'h0000_0000;
    phase_base[1] = 29'h1FFF_FFFF;
    phase_base[2] = 29'($urandom);
    phase_base[3] = csds_pkg::BASE_RESET;

    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_scratch_base(csds_pkg::BASE_RESET);

    // Directed: window hits in both cached aliases, size masking, isolation,
    // cache control, bus errors and misaligned accesses
    queue_access(csds_pkg::KIND_STORE, SZ_WORD, 32'h1F80_0000, 32'h1122_3344, 1'b0,
                 $urandom_range(0, 14));
    queue_access(KIND_LOAD, SZ_WORD, 32'h9F80_0000, 32'h0, 1'b0, $urandom_range(0, 14));
    queue_access(csds_pkg::KIND_STORE, csds_pkg::SZ_BYTE, 32'h1F80_0001, 32'hFFFF_FFAB,
                 1'b0, 0);
    queue_access(KIND_LOAD, csds_pkg::SZ_HALF, 32'h1F80_0000, 32'hFFFF_FFFF, 1'b0, 0);
    queue_access(csds_pkg::KIND_STORE, SZ_WORD, 32'h9F80_03FC, 32'hFFFF_FFFF, 1'b0, 0);
    queue_access(KIND_LOAD, csds_pkg::SZ_BYTE, 32'h1F80_03FF, 32'h0, 1'b0,
                 $urandom_range(0, 14));
    queue_access(csds_pkg::KIND_STORE, csds_pkg::SZ_HALF, 32'h1F80_0000, 32'h0000_5555,
                 1'b1, 0);
    queue_access(KIND_LOAD, SZ_WORD, 32'h1F80_0000, 32'h0, 1'b1, 0);
    queue_access(csds_pkg::KIND_STORE, csds_pkg::SZ_HALF, 32'hA000_0002, 32'hDEAD_BEEF,
                 1'b1, 0);
    queue_access(csds_pkg::KIND_STORE, csds_pkg::SZ_BYTE, 32'h0000_0000, 32'hFFFF_FFFF,
                 1'b0, 0);
    queue_access(KIND_LOAD, SZ_WORD, 32'h0000_0000, 32'h0, 1'b0, $urandom_range(0, 14));
    queue_access(csds_pkg::KIND_STORE, SZ_WORD, csds_pkg::CACHE_CTRL_ADDR, 32'hFFFF_FFFF,
                 1'b0, 0);
    queue_access(KIND_LOAD, csds_pkg::SZ_BYTE, csds_pkg::CACHE_CTRL_ADDR, 32'h0, 1'b0, 0);
    queue_access(csds_pkg::KIND_STORE, csds_pkg::SZ_BYTE, csds_pkg::CACHE_CTRL_ADDR,
                 32'h1234_5678, 1'b1, 0);
    queue_access(KIND_LOAD, SZ_ODD, csds_pkg::CACHE_CTRL_ADDR, 32'h0, 1'b0, 0);
    queue_access(KIND_LOAD, SZ_WORD, 32'hC000_0000, 32'h0, 1'b0, $urandom_range(0, 14));
    queue_access(csds_pkg::KIND_STORE, csds_pkg::SZ_BYTE, 32'h2000_0000, 32'hFFFF_FFFF,
                 1'b0, 0);
    queue_access(KIND_LOAD, SZ_WORD, 32'h7FFF_FFFC, 32'h0, 1'b0, 0);
    queue_access(KIND_LOAD, csds_pkg::SZ_HALF, 32'h2000_0001, 32'h0, 1'b0, 0);
    queue_access(csds_pkg::KIND_STORE, SZ_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0);
    queue_access(KIND_LOAD, SZ_ODD, 32'h0000_0002, 32'h0, 1'b0, 0);
    queue_access(KIND_LOAD, csds_pkg::SZ_BYTE, 32'hFFFF_FFFF, 32'h0, 1'b0,
                 $urandom_range(0, 14));
    queue_access(csds_pkg::KIND_STORE, SZ_ODD, 32'h9F80_0010, 32'hCAFE_F00D, 1'b0, 0);
    queue_access(KIND_LOAD, SZ_WORD, 32'h9F80_0010, 32'h0, 1'b0, 0);
    queue_access(KIND_LOAD, SZ_WORD, 32'hBF80_0010, 32'h0, 1'b0, 0);
    wait_drained();

    // Random phases, each under its own window base; odd phases run without idling
    for (int p = 0; p < 4; p++) begin
      write_scratch_base(phase_base[p]);
      rx_calm = (p % 2 == 1);
      fill_random(RANDOM_PHASE, (p % 2 == 1));
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
